### rtl/core/hcc_pkg.sv
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared widths, register indexes, reset values and the configuration bundle
// of the heat/cool hysteresis controller.
// ----------------------------------------------------------------------------
`default_nettype none

package hcc_pkg;

  localparam int TEMP_W     = 15;
  localparam int TEMP_EXT_W = TEMP_W + 2;
  localparam int HYST_W     = 11;
  localparam int LOCK_W     = 16;
  localparam int MS_W       = 10;
  localparam int LOCK_MS_W  = LOCK_W + MS_W;
  localparam int TIME_W     = 32;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [LOCK_MS_W-1:0] MS_PER_SEC = LOCK_MS_W'(1000);

  localparam logic [HYST_W-1:0]    HYST_RST    = HYST_W'(50);
  localparam logic [LOCK_W-1:0]    LOCK_RST    = LOCK_W'(180);
  localparam logic [LOCK_MS_W-1:0] LOCK_MS_RST = LOCK_MS_W'(180000);

  typedef enum logic [0:0] {
    REG_HYST = 1'b0,
    REG_LOCK = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [HYST_W-1:0]    hyst;
    logic [LOCK_MS_W-1:0] lockout_ms;
  } hcc_cfg_t;

endpackage

`default_nettype wire

### rtl/core/heat_cool_hysteresis_control.sv
// ----------------------------------------------------------------------------
// heat_cool_hysteresis_control
// Bang-bang heater/cooler control with hysteresis and a cooler restart lockout.
// ----------------------------------------------------------------------------
// Takes one control sample per clock. A sample is captured in an input
// register, the relay decision and lockout compare are made from it and the
// held relay states combinationally, and the result is registered in an
// output register when the sample steps. The only feedback is the relay
// state and last cooler off time, both updated with the output register,
// so the sustained rate is one sample per clock while the output side takes
// results. The cooler lockout also runs from timestamp zero after reset.
`default_nettype none

module heat_cool_hysteresis_control (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [hcc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [hcc_pkg::DATA_W-1:0] pwdata,
  output logic      [hcc_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [hcc_pkg::TEMP_W-1:0] measured_temp,
  input  wire logic [hcc_pkg::TEMP_W-1:0] target_temp,
  input  wire logic                       heater_allowed,
  input  wire logic                       cooler_allowed,
  input  wire logic [hcc_pkg::TIME_W-1:0] now_ms,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            heater_on,
  output logic                            cooler_on,
  output logic                            cooler_locked
);
  import hcc_pkg::*;

  hcc_cfg_t cfg;

  hcc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic              s1_valid;
  logic [TEMP_W-1:0] s1_meas;
  logic [TEMP_W-1:0] s1_targ;
  logic              s1_heat_ok;
  logic              s1_cool_ok;
  logic [TIME_W-1:0] s1_now;

  // relay state
  logic              heater_state;
  logic              cooler_state;
  logic [TIME_W-1:0] last_off;

  logic advance;
  logic in_xfer;
  logic step;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_xfer  = in_valid && !in_stall;
  assign step     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_meas    <= measured_temp;
      s1_targ    <= target_temp;
      s1_heat_ok <= heater_allowed;
      s1_cool_ok <= cooler_allowed;
      s1_now     <= now_ms;
    end
  end

  // decision
  logic signed [TEMP_EXT_W-1:0] meas;
  logic signed [TEMP_EXT_W-1:0] targ;
  logic signed [TEMP_EXT_W-1:0] hyst;
  logic signed [TEMP_EXT_W-1:0] targ_lo;
  logic signed [TEMP_EXT_W-1:0] targ_hi;
  logic [TIME_W-1:0]            elapsed;
  logic                         locked;
  logic                         heater_next;
  logic                         cooler_next;
  logic                         cooler_off_now;

  always_comb begin
    meas    = $signed({{2{s1_meas[TEMP_W-1]}}, s1_meas});
    targ    = $signed({{2{s1_targ[TEMP_W-1]}}, s1_targ});
    hyst    = $signed({{(TEMP_EXT_W-HYST_W){1'b0}}, cfg.hyst});
    targ_lo = targ - hyst;
    targ_hi = targ + hyst;
    elapsed = s1_now - last_off;
    locked  = elapsed < {{(TIME_W-LOCK_MS_W){1'b0}}, cfg.lockout_ms};

    heater_next = heater_state;
    if (s1_heat_ok && !cooler_state) begin
      if (!heater_state && (meas <= targ_lo)) begin
        heater_next = 1'b1;
      end else if (heater_state && (meas >= targ)) begin
        heater_next = 1'b0;
      end
    end else if (!s1_heat_ok) begin
      heater_next = 1'b0;
    end

    cooler_next    = cooler_state;
    cooler_off_now = 1'b0;
    if (s1_cool_ok && !heater_state && !locked) begin
      if (!cooler_state && (meas >= targ_hi)) begin
        cooler_next = 1'b1;
      end else if (cooler_state && (meas <= targ)) begin
        cooler_next    = 1'b0;
        cooler_off_now = 1'b1;
      end
    end else if (!s1_cool_ok && cooler_state) begin
      cooler_next    = 1'b0;
      cooler_off_now = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heater_state <= 1'b0;
      cooler_state <= 1'b0;
      last_off     <= '0;
    end else if (step) begin
      heater_state <= heater_next;
      cooler_state <= cooler_next;
      if (cooler_off_now) begin
        last_off <= s1_now;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      heater_on     <= heater_next;
      cooler_on     <= cooler_next;
      cooler_locked <= locked;
    end
  end

  // relay state only moves on a sample step
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(step) |-> $stable(heater_state) && $stable(cooler_state))
    else $error("relay state changed without a sample step");

  // a stepped sample always reaches the result register
  assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("stepped sample did not produce a result");

  // cooler never starts while locked out
  assert property (@(posedge clk) disable iff (rst)
    step && locked && !cooler_state |=> !cooler_state)
    else $error("cooler started during lockout");

  // off time is recorded whenever the cooler switches off
  assert property (@(posedge clk) disable iff (rst)
    step && cooler_state && !cooler_next |=> last_off == $past(s1_now))
    else $error("cooler off time not recorded");

  // result register holds the relay state it reports
  assert property (@(posedge clk) disable iff (rst)
    step |=> heater_on == heater_state && cooler_on == cooler_state)
    else $error("result does not match relay state");

endmodule

`default_nettype wire

### rtl/core/hcc_regs.sv
// ----------------------------------------------------------------------------
// hcc_regs
// Configuration register file on an APB-style port. Keeps the lockout in
// seconds for readback and also in milliseconds for the lockout compare.
// ----------------------------------------------------------------------------
`default_nettype none

module hcc_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [hcc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [hcc_pkg::DATA_W-1:0] pwdata,
  output logic      [hcc_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output hcc_pkg::hcc_cfg_t               cfg
);
  import hcc_pkg::*;

  logic [HYST_W-1:0]    hyst;
  logic [LOCK_W-1:0]    lockout_sec;
  logic [LOCK_MS_W-1:0] lockout_ms;
  logic                 wr_en;
  reg_idx_t             idx;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hyst        <= HYST_RST;
      lockout_sec <= LOCK_RST;
      lockout_ms  <= LOCK_MS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_HYST: hyst <= pwdata[HYST_W-1:0];
        REG_LOCK: begin
          lockout_sec <= pwdata[LOCK_W-1:0];
          lockout_ms  <= {{MS_W{1'b0}}, pwdata[LOCK_W-1:0]} * MS_PER_SEC;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HYST: prdata = {{(DATA_W-HYST_W){1'b0}}, hyst};
      REG_LOCK: prdata = {{(DATA_W-LOCK_W){1'b0}}, lockout_sec};
      default:  prdata = '0;
    endcase
  end

  assign cfg.hyst       = hyst;
  assign cfg.lockout_ms = lockout_ms;

endmodule

`default_nettype wire
